// ===== hdl/chord_function_labeler_defines.svh =====
// Assertion macros for the chord function labeler.
// Included by the top level; relies on i_clk and i_rst_n being in scope.
`ifndef CHORD_FUNCTION_LABELER_DEFINES_SVH
`define CHORD_FUNCTION_LABELER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CFL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked after a delay that matches the pipeline depth.
`define CFL_ASSERT_LAT2(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ===== hdl/cfl_pkg.sv =====
// Package for the chord function labeler: payload structs, codes,
// confidence constants and the small lookup functions. No dependencies.
package cfl_pkg;

    localparam int unsigned PC_W    = 4;
    localparam int unsigned MASK_W  = 12;
    localparam int unsigned CFG_W   = 4;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TONIC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MINOR = 1'b1;

    // Label kinds
    localparam logic [2:0] KIND_DIATONIC  = 3'd0;
    localparam logic [2:0] KIND_LEADING   = 3'd1;
    localparam logic [2:0] KIND_SECONDARY = 3'd2;
    localparam logic [2:0] KIND_TRITONE   = 3'd3;
    localparam logic [2:0] KIND_NONDIAT   = 3'd4;

    // Quality suffixes
    localparam logic [2:0] SUF_NONE  = 3'd0;
    localparam logic [2:0] SUF_SEVEN = 3'd1;
    localparam logic [2:0] SUF_MAJ7  = 3'd2;
    localparam logic [2:0] SUF_DIM   = 3'd3;
    localparam logic [2:0] SUF_HDIM7 = 3'd4;
    localparam logic [2:0] SUF_AUG   = 3'd5;

    // Harmonic roles
    localparam logic [1:0] ROLE_TONIC    = 2'd0;
    localparam logic [1:0] ROLE_SUBDOM   = 2'd1;
    localparam logic [1:0] ROLE_DOMINANT = 2'd2;
    localparam logic [1:0] ROLE_OTHER    = 2'd3;

    // Confidences in hundredths
    localparam logic [6:0] CONF_MAJ_DIATONIC  = 7'd95;
    localparam logic [6:0] CONF_MAJ_SECONDARY = 7'd75;
    localparam logic [6:0] CONF_MAJ_TRITONE   = 7'd55;
    localparam logic [6:0] CONF_MIN_DIATONIC  = 7'd90;
    localparam logic [6:0] CONF_MIN_LEADING   = 7'd75;
    localparam logic [6:0] CONF_MIN_SECONDARY = 7'd70;
    localparam logic [6:0] CONF_MIN_TRITONE   = 7'd50;
    localparam logic [6:0] CONF_NONDIAT       = 7'd25;

    // Interval bit positions within the mask
    localparam int unsigned IV_MIN3 = 3;
    localparam int unsigned IV_MAJ3 = 4;
    localparam int unsigned IV_DIM5 = 6;
    localparam int unsigned IV_P5   = 7;
    localparam int unsigned IV_AUG5 = 8;
    localparam int unsigned IV_MIN7 = 10;
    localparam int unsigned IV_MAJ7 = 11;

    localparam logic [PC_W-1:0] REL_SEMITONE = 4'd1;
    localparam logic [PC_W-1:0] REL_LEADING  = 4'd11;
    localparam logic [2:0]      DEG_FIFTH    = 3'd5;

    typedef struct packed {
        logic [PC_W-1:0]   chord_root;
        logic [MASK_W-1:0] interval_mask;
        logic              minor_tag;
    } t_chord_in;

    typedef struct packed {
        logic [2:0] label_kind;
        logic [2:0] degree;
        logic       upper_case;
        logic [2:0] quality_suffix;
        logic [1:0] harmonic_role;
        logic [6:0] confidence;
    } t_label_out;

    // Pitch classes 12..15 fold back into 0..3.
    function automatic logic [PC_W-1:0] pc_reduce(input logic [PC_W-1:0] p);
        return (p >= 4'd12) ? p - 4'd12 : p;
    endfunction

    // Scale degree of a pitch class relative to the tonic; 0 when outside the key.
    // The minor scale is natural minor with the raised leading tone added as degree 7.
    function automatic logic [2:0] scale_degree(input logic minor, input logic [PC_W-1:0] rel);
        logic [2:0] d;
        d = 3'd0;
        if (minor) begin
            case (rel)
                4'd0:  d = 3'd1;
                4'd2:  d = 3'd2;
                4'd3:  d = 3'd3;
                4'd5:  d = 3'd4;
                4'd7:  d = 3'd5;
                4'd8:  d = 3'd6;
                4'd10: d = 3'd7;
                4'd11: d = 3'd7;
                default: d = 3'd0;
            endcase
        end else begin
            case (rel)
                4'd0:  d = 3'd1;
                4'd2:  d = 3'd2;
                4'd4:  d = 3'd3;
                4'd5:  d = 3'd4;
                4'd7:  d = 3'd5;
                4'd9:  d = 3'd6;
                4'd11: d = 3'd7;
                default: d = 3'd0;
            endcase
        end
        return d;
    endfunction

    function automatic logic [1:0] degree_role(input logic [2:0] d);
        logic [1:0] r;
        case (d)
            3'd1, 3'd3, 3'd6: r = ROLE_TONIC;
            3'd2, 3'd4:       r = ROLE_SUBDOM;
            3'd5, 3'd7:       r = ROLE_DOMINANT;
            default:          r = ROLE_OTHER;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/chord_function_labeler.sv =====
// Chord function labeler top level: input register, classification logic, result register.
// Depends on cfl_pkg and chord_function_labeler_defines.svh.
//
//  channel  | handshake          | payload              | notes
//  ---------+--------------------+----------------------+------------------------------
//  chord    | start / busy       | i_chord (t_chord_in) | transaction when start && !busy
//  label    | o_strobe           | o_label (t_label_out)| one cycle, cannot be held off
//  config   | i_cfg_we           | i_cfg_index/data     | written at the edge, no wait
//
// Each chord goes from acceptance to its label through the input register and then
// through the classification logic into the result register.
// A new chord is accepted every cycle; busy is never raised.
// Synchronous active-low reset clears the valid flags and sets the key to C major.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`include "chord_function_labeler_defines.svh"

module chord_function_labeler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cfl_pkg::t_chord_in                  i_chord,
    output logic                                o_strobe,
    output cfl_pkg::t_label_out                 o_label,
    input  logic                                i_cfg_we,
    input  logic [cfl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cfl_pkg::CFG_W-1:0]           i_cfg_data
);

    logic [cfl_pkg::PC_W-1:0] r_key_tonic;
    logic                     r_key_minor;
    logic                     r_in_vld;
    cfl_pkg::t_chord_in       r_in;
    logic                     r_out_vld;
    cfl_pkg::t_label_out      r_out;
    cfl_pkg::t_label_out      n_out;

    logic                     accept;
    logic [cfl_pkg::PC_W-1:0] root;
    logic [cfl_pkg::PC_W-1:0] tonic;
    logic [cfl_pkg::PC_W:0]   rel_sum;
    logic [cfl_pkg::PC_W:0]   rel_wrap;
    logic [cfl_pkg::PC_W-1:0] rel;
    logic [cfl_pkg::PC_W:0]   trel_sum;
    logic [cfl_pkg::PC_W:0]   trel_wrap;
    logic [cfl_pkg::PC_W-1:0] trel;
    logic [2:0]               deg;
    logic [2:0]               tdeg;
    logic min3, maj3, dim5, p5, aug5, min7, maj7;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_tonic <= '0;
            r_key_minor <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cfl_pkg::CFG_KEY_TONIC: r_key_tonic <= i_cfg_data;
                cfl_pkg::CFG_KEY_MINOR: r_key_minor <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_chord;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        root  = cfl_pkg::pc_reduce(r_in.chord_root);
        tonic = cfl_pkg::pc_reduce(r_key_tonic);

        rel_sum  = {1'b0, root} + 5'd12 - {1'b0, tonic};
        rel_wrap = (rel_sum >= 5'd12) ? rel_sum - 5'd12 : rel_sum;
        rel      = rel_wrap[cfl_pkg::PC_W-1:0];

        // A fifth below the root is seven semitones down, i.e. five up.
        trel_sum  = {1'b0, rel} + 5'd5;
        trel_wrap = (trel_sum >= 5'd12) ? trel_sum - 5'd12 : trel_sum;
        trel      = trel_wrap[cfl_pkg::PC_W-1:0];

        deg  = cfl_pkg::scale_degree(r_key_minor, rel);
        tdeg = cfl_pkg::scale_degree(r_key_minor, trel);

        min3 = r_in.interval_mask[cfl_pkg::IV_MIN3];
        maj3 = r_in.interval_mask[cfl_pkg::IV_MAJ3];
        dim5 = r_in.interval_mask[cfl_pkg::IV_DIM5];
        p5   = r_in.interval_mask[cfl_pkg::IV_P5];
        aug5 = r_in.interval_mask[cfl_pkg::IV_AUG5];
        min7 = r_in.interval_mask[cfl_pkg::IV_MIN7];
        maj7 = r_in.interval_mask[cfl_pkg::IV_MAJ7];

        n_out.label_kind     = cfl_pkg::KIND_NONDIAT;
        n_out.degree         = 3'd0;
        n_out.upper_case     = 1'b0;
        n_out.quality_suffix = cfl_pkg::SUF_NONE;
        n_out.harmonic_role  = cfl_pkg::ROLE_OTHER;
        n_out.confidence     = cfl_pkg::CONF_NONDIAT;

        // A dominant seventh off the fifth degree is read as applied to its target first.
        if (maj3 && min7 && deg != cfl_pkg::DEG_FIFTH && tdeg != 3'd0) begin
            n_out.label_kind    = cfl_pkg::KIND_SECONDARY;
            n_out.degree        = tdeg;
            n_out.upper_case    = 1'b1;
            n_out.harmonic_role = cfl_pkg::ROLE_DOMINANT;
            n_out.confidence    = r_key_minor ? cfl_pkg::CONF_MIN_SECONDARY
                                              : cfl_pkg::CONF_MAJ_SECONDARY;
        end else if (maj3 && min7 && deg != cfl_pkg::DEG_FIFTH
                     && rel == cfl_pkg::REL_SEMITONE) begin
            n_out.label_kind    = cfl_pkg::KIND_TRITONE;
            n_out.upper_case    = 1'b1;
            n_out.harmonic_role = cfl_pkg::ROLE_DOMINANT;
            n_out.confidence    = r_key_minor ? cfl_pkg::CONF_MIN_TRITONE
                                              : cfl_pkg::CONF_MAJ_TRITONE;
        end else if (deg != 3'd0) begin
            if (min3 && dim5) begin
                n_out.upper_case     = 1'b0;
                n_out.quality_suffix = min7 ? cfl_pkg::SUF_HDIM7 : cfl_pkg::SUF_DIM;
            end else if (maj3 && aug5) begin
                n_out.upper_case     = 1'b1;
                n_out.quality_suffix = cfl_pkg::SUF_AUG;
            end else begin
                n_out.upper_case     = !(min3 && (p5 || r_in.minor_tag));
                n_out.quality_suffix = min7 ? cfl_pkg::SUF_SEVEN
                                     : (maj7 ? cfl_pkg::SUF_MAJ7 : cfl_pkg::SUF_NONE);
            end
            n_out.degree        = deg;
            n_out.harmonic_role = cfl_pkg::degree_role(deg);
            if (r_key_minor && rel == cfl_pkg::REL_LEADING) begin
                n_out.label_kind = cfl_pkg::KIND_LEADING;
                n_out.confidence = cfl_pkg::CONF_MIN_LEADING;
            end else begin
                n_out.label_kind = cfl_pkg::KIND_DIATONIC;
                n_out.confidence = r_key_minor ? cfl_pkg::CONF_MIN_DIATONIC
                                               : cfl_pkg::CONF_MAJ_DIATONIC;
            end
        end
    end

    assign o_strobe = r_out_vld;
    assign o_label  = r_out;

    // Every accepted transaction yields exactly one label after passing both registers, and no other.
    `CFL_ASSERT_LAT2(a_accept_gives_label, start && !busy, o_strobe,
        "accepted chord produced no label")
    `CFL_ASSERT_NOW(a_label_has_source, o_strobe, $past(start, 2) && !$past(busy, 2),
        "label strobed without an accepted chord")
    `CFL_ASSERT_NOW(a_nondiat_fields,
        o_strobe && o_label.label_kind == cfl_pkg::KIND_NONDIAT,
        o_label.degree == 3'd0 && o_label.confidence == cfl_pkg::CONF_NONDIAT,
        "non-diatonic label carries a degree or wrong confidence")
    `CFL_ASSERT_NOW(a_leading_only_minor,
        o_strobe && o_label.label_kind == cfl_pkg::KIND_LEADING,
        r_key_minor && o_label.degree == 3'd7,
        "leading-tone label outside a minor key")

endmodule

// ===== test/tb_chord_function_labeler.sv =====
// Self-checking testbench for chord_function_labeler: directed and random chords under
// several key settings, each label checked against an in-bench predictor.
// Depends on cfl_pkg and the chord_function_labeler RTL only.
module tb_chord_function_labeler;
    import cfl_pkg::*;

    // Scale degree per semitone above the tonic, one nibble each, semitone 0 in the lowest.
    localparam logic [47:0] MAJOR_DEGREES = 48'h7060_5043_0201;
    localparam logic [47:0] MINOR_DEGREES = 48'h7706_5040_3201;
    localparam int          TIMEOUT_CYCLES = 200000;
    localparam int          DRAIN_LIMIT    = 1000;
    localparam int          SETTLE_CYCLES  = 4;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_chord_in            i_chord;
    logic                 o_strobe;
    t_label_out           o_label;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    t_label_out expected_labels[$];
    logic [3:0] cur_tonic;
    logic       cur_minor_key;
    int         idle_pct;
    int         mismatches;

    chord_function_labeler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_chord     (i_chord),
        .o_strobe    (o_strobe),
        .o_label     (o_label),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [2:0] degree_of(input logic minor_key, input int semis);
        logic [47:0] degrees;
        degrees = minor_key ? MINOR_DEGREES : MAJOR_DEGREES;
        return degrees[semis*4 +: 3];
    endfunction

    function automatic logic [1:0] role_of(input logic [2:0] deg);
        logic [1:0] r;
        if (deg == 3'd0)
            r = ROLE_OTHER;
        else if (deg == 3'd5 || deg == 3'd7)
            r = ROLE_DOMINANT;
        else if (deg == 3'd2 || deg == 3'd4)
            r = ROLE_SUBDOM;
        else
            r = ROLE_TONIC;
        return r;
    endfunction

    function automatic t_label_out label_chord(input t_chord_in c, input logic [3:0] tonic_reg,
                                               input logic minor_key);
        t_label_out lab;
        int         root;
        int         tonic;
        int         semis;
        logic [2:0] deg;
        logic [2:0] target;
        logic [11:0] m;
        logic       claimed;
        root  = int'(c.chord_root) % 12;
        tonic = int'(tonic_reg) % 12;
        semis = (root + 12 - tonic) % 12;
        deg   = degree_of(minor_key, semis);
        m     = c.interval_mask;
        claimed = 1'b0;
        lab.label_kind     = KIND_NONDIAT;
        lab.degree         = 3'd0;
        lab.upper_case     = 1'b0;
        lab.quality_suffix = SUF_NONE;
        lab.harmonic_role  = ROLE_OTHER;
        lab.confidence     = CONF_NONDIAT;
        // A dominant seventh on anything but the fifth degree may point at another degree.
        if (m[IV_MAJ3] && m[IV_MIN7] && deg != DEG_FIFTH) begin
            target = degree_of(minor_key, (semis + 5) % 12);
            if (target != 3'd0) begin
                lab.label_kind = KIND_SECONDARY;
                lab.degree     = target;
                lab.confidence = minor_key ? CONF_MIN_SECONDARY : CONF_MAJ_SECONDARY;
                claimed        = 1'b1;
            end else if (semis == 1) begin
                lab.label_kind = KIND_TRITONE;
                lab.confidence = minor_key ? CONF_MIN_TRITONE : CONF_MAJ_TRITONE;
                claimed        = 1'b1;
            end
            if (claimed) begin
                lab.upper_case    = 1'b1;
                lab.harmonic_role = ROLE_DOMINANT;
            end
        end
        if (!claimed && deg != 3'd0) begin
            if (m[IV_MIN3] && m[IV_DIM5]) begin
                lab.upper_case     = 1'b0;
                lab.quality_suffix = m[IV_MIN7] ? SUF_HDIM7 : SUF_DIM;
            end else if (m[IV_MAJ3] && m[IV_AUG5]) begin
                lab.upper_case     = 1'b1;
                lab.quality_suffix = SUF_AUG;
            end else begin
                lab.upper_case     = !(m[IV_MIN3] && (m[IV_P5] || c.minor_tag));
                lab.quality_suffix = m[IV_MIN7] ? SUF_SEVEN : (m[IV_MAJ7] ? SUF_MAJ7 : SUF_NONE);
            end
            lab.degree        = deg;
            lab.harmonic_role = role_of(deg);
            if (minor_key && semis == 11) begin
                lab.label_kind = KIND_LEADING;
                lab.confidence = CONF_MIN_LEADING;
            end else begin
                lab.label_kind = KIND_DIATONIC;
                lab.confidence = minor_key ? CONF_MIN_DIATONIC : CONF_MAJ_DIATONIC;
            end
        end
        return lab;
    endfunction

    // Every label on the strobe is matched against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_label_out want;
        if (i_rst_n && o_strobe) begin
            if (expected_labels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected label %p", o_label);
            end else begin
                want = expected_labels.pop_front();
                if (o_label.label_kind !== want.label_kind ||
                    o_label.degree !== want.degree ||
                    o_label.upper_case !== want.upper_case ||
                    o_label.quality_suffix !== want.quality_suffix ||
                    o_label.harmonic_role !== want.harmonic_role ||
                    o_label.confidence !== want.confidence) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("label mismatch: expected %p, got %p", want, o_label);
                end
            end
        end
    end

    task automatic send_chord(input logic [3:0] root, input logic [11:0] mask, input logic tag);
        t_chord_in c;
        c.chord_root    = root;
        c.interval_mask = mask;
        c.minor_tag     = tag;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start   = 1'b1;
        i_chord = c;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        expected_labels.push_back(label_chord(c, cur_tonic, cur_minor_key));
    endtask

    task automatic wait_for_labels();
        int n;
        n = 0;
        @(negedge i_clk);
        start = 1'b0;
        while (expected_labels.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_for_labels();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        if (idx == CFG_KEY_TONIC)
            cur_tonic = val;
        else
            cur_minor_key = val[0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_key(input logic [3:0] tonic, input logic minor_key);
        write_reg(CFG_KEY_TONIC, tonic);
        write_reg(CFG_KEY_MINOR, {3'b000, minor_key});
    endtask

    // Runs under the reset key, C major: every quality and every label kind but the minor-only leading-tone kind.
    task automatic test_major_key();
        send_chord(4'd0, 12'h091, 1'b0);
        send_chord(4'd2, 12'h489, 1'b0);
        send_chord(4'd11, 12'h449, 1'b0);
        send_chord(4'd11, 12'h049, 1'b0);
        send_chord(4'd0, 12'h111, 1'b0);
        send_chord(4'd9, 12'h009, 1'b1);
        send_chord(4'd5, 12'h891, 1'b0);
        send_chord(4'd7, 12'h491, 1'b0);
        send_chord(4'd2, 12'h491, 1'b0);
        send_chord(4'd1, 12'h491, 1'b0);
        send_chord(4'd6, 12'h491, 1'b0);
        send_chord(4'd3, 12'h491, 1'b0);
        send_chord(4'd0, 12'h000, 1'b0);
        send_chord(4'd0, 12'hFFF, 1'b1);
    endtask

    // A minor: leading tone, subtonic, secondary dominant and tritone substitute.
    task automatic test_minor_key();
        set_key(4'd9, 1'b1);
        send_chord(4'd8, 12'h049, 1'b0);
        send_chord(4'd8, 12'h091, 1'b0);
        send_chord(4'd7, 12'h091, 1'b0);
        send_chord(4'd4, 12'h491, 1'b0);
        send_chord(4'd9, 12'h491, 1'b0);
        send_chord(4'd10, 12'h491, 1'b0);
        send_chord(4'd0, 12'h089, 1'b0);
    endtask

    // Roots and tonics above eleven fold back into the octave.
    task automatic test_folded_pitch();
        set_key(4'd15, 1'b0);
        send_chord(4'd15, 12'h091, 1'b0);
        send_chord(4'd13, 12'h491, 1'b0);
        send_chord(4'd14, 12'hFFF, 1'b1);
        send_chord(4'd12, 12'h489, 1'b1);
    endtask

    task automatic test_random(input int n, input int pct, input logic [3:0] tonic,
                               input logic minor_key);
        logic [11:0] shapes [0:8];
        logic [11:0] mask;
        logic [3:0]  root;
        shapes[0] = 12'h091;
        shapes[1] = 12'h089;
        shapes[2] = 12'h049;
        shapes[3] = 12'h111;
        shapes[4] = 12'h491;
        shapes[5] = 12'h891;
        shapes[6] = 12'h489;
        shapes[7] = 12'h449;
        shapes[8] = 12'h249;
        set_key(tonic, minor_key);
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            // Mostly real chord shapes on in-range roots, with some raw masks and folded roots.
            if ($urandom_range(99) < 80)
                mask = shapes[$urandom_range(8)];
            else
                mask = 12'($urandom);
            if ($urandom_range(99) < 10)
                mask = mask ^ (12'd1 << $urandom_range(11));
            root = ($urandom_range(99) < 90) ? 4'($urandom_range(11)) : 4'($urandom_range(15));
            send_chord(root, mask, 1'($urandom));
        end
        idle_pct = 0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_chord       = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_KEY_TONIC;
        i_cfg_data    = '0;
        cur_tonic     = 4'd0;
        cur_minor_key = 1'b0;
        idle_pct      = 0;
        mismatches    = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_major_key();
        test_minor_key();
        test_folded_pitch();
        test_random(125, 0, 4'd0, 1'b0);
        test_random(125, 62, 4'd11, 1'b1);
        test_random(125, 29, 4'd0, 1'b1);
        test_random(125, 0, 4'd15, 1'b1);
        test_random(125, 62, 4'($urandom_range(11)), 1'b0);
        test_random(125, 29, 4'd11, 1'b0);

        wait_for_labels();
        mismatches += expected_labels.size();
        if (expected_labels.size() != 0)
            $display("%0d labels never arrived", expected_labels.size());
        @(negedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
